// ----- hdl/adcst_pkg.sv -----
// Shared constants, request codes and controller/datapath interface types for the ADC statistics block.
package adcst_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int COUNT_BITS   = 16;
    localparam int CHANNEL_BASE = 8;

    localparam int VAL_W    = 24;
    localparam int CODE_W   = 8;
    localparam int IDX_W    = 4;
    localparam int SUM_W    = VAL_W + COUNT_BITS;
    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DIVCNT_W = $clog2(VAL_W + 1);

    localparam int S_TDATA_W = ((CODE_W + VAL_W + 7) / 8) * 8;
    localparam int M_FIELD_W = IDX_W + 3 * VAL_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef struct packed {
        logic take_req;    // capture the incoming request
        logic smp_update;  // read-modify-write of one channel entry
        logic rep_start;   // rewind the report channel counter
        logic rep_load;    // fetch and clear one channel, prime the divider
        logic div_step;    // one quotient bit
        logic out_load;    // move the finished result to the output register
        logic next_ch;     // advance to the next report channel
    } cmd_t;

    typedef struct packed {
        logic req_report;  // captured request is a report
        logic div_last;    // the current division step is the final one
        logic last_ch;     // the report channel is the highest one
        logic out_free;    // the output register can take a result this cycle
    } stat_t;

endpackage

// ----- hdl/adcst_ctrl.sv -----
// Controller state machine sequencing sample updates and channel reports.
module adcst_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            in_ready,
    input  adcst_pkg::stat_t stat,
    output adcst_pkg::cmd_t  cmd
);
    import adcst_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CAPT = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.take_req = 1'b1;
                    state_next   = ST_CAPT;
                end
            end
            ST_CAPT: begin
                if (stat.req_report) begin
                    cmd.rep_start = 1'b1;
                    state_next    = ST_LOAD;
                end else begin
                    cmd.smp_update = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_LOAD: begin
                cmd.rep_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.last_ch) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_ch = 1'b1;
                        state_next  = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/adcst_dp.sv -----
// Datapath: per-channel accumulators, serial divider for the mean and the result register.
module adcst_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_req,
    input  logic [adcst_pkg::CODE_W-1:0]      in_code,
    input  logic [adcst_pkg::VAL_W-1:0]       in_value,
    input  adcst_pkg::cmd_t                   cmd,
    output adcst_pkg::stat_t                  stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [adcst_pkg::IDX_W-1:0]       out_idx,
    output logic [adcst_pkg::VAL_W-1:0]       out_max,
    output logic [adcst_pkg::VAL_W-1:0]       out_min,
    output logic [adcst_pkg::VAL_W-1:0]       out_mean,
    output logic                              out_empty,
    output logic                              out_ovf,
    output logic                              out_last
);
    import adcst_pkg::*;

    // Captured request
    logic              req_reg;
    logic [CODE_W-1:0] code_reg;
    logic [VAL_W-1:0]  value_reg;

    // Channel accumulators
    logic [VAL_W-1:0]      max_reg [NUM_CHANNELS];
    logic [VAL_W-1:0]      min_reg [NUM_CHANNELS];
    logic [SUM_W-1:0]      sum_reg [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] cnt_reg [NUM_CHANNELS];
    logic                  ovf_reg [NUM_CHANNELS];

    // Report and divider state
    logic [CH_W-1:0]       rep_ch_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic [VAL_W-1:0]      quo_reg;
    logic [DIVCNT_W-1:0]   div_cnt_reg;
    logic [VAL_W-1:0]      rmax_reg;
    logic [VAL_W-1:0]      rmin_reg;
    logic                  rempty_reg;
    logic                  rovf_reg;
    logic                  out_valid_reg;

    logic [CODE_W-1:0]     code_off;
    logic                  in_range;
    logic [CH_W-1:0]       rd_idx;
    logic [VAL_W-1:0]      rd_max;
    logic [VAL_W-1:0]      rd_min;
    logic [SUM_W-1:0]      rd_sum;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  cnt_full;
    logic [COUNT_BITS:0]   partial;
    logic                  quo_bit;
    logic [COUNT_BITS-1:0] rem_next;
    logic [VAL_W-1:0]      quo_next;

    assign code_off = code_reg - CODE_W'(CHANNEL_BASE);
    assign in_range = (code_reg >= CODE_W'(CHANNEL_BASE)) &&
                      ({1'b0, code_off} < (CODE_W + 1)'(NUM_CHANNELS));

    // One read port shared by sample updates and report fetches
    assign rd_idx   = cmd.smp_update ? CH_W'(code_off) : rep_ch_reg;
    assign rd_max   = max_reg[rd_idx];
    assign rd_min   = min_reg[rd_idx];
    assign rd_sum   = sum_reg[rd_idx];
    assign rd_cnt   = cnt_reg[rd_idx];
    assign cnt_full = (rd_cnt == '1);

    // Restoring division: the quotient fits VAL_W bits because sum <= count * max
    assign partial  = {rem_reg, quo_reg[VAL_W-1]};
    assign quo_bit  = (partial >= {1'b0, dvs_reg});
    assign rem_next = quo_bit ? COUNT_BITS'(partial - {1'b0, dvs_reg})
                              : partial[COUNT_BITS-1:0];
    assign quo_next = {quo_reg[VAL_W-2:0], quo_bit};

    assign stat.req_report = (req_reg == REQ_REPORT);
    assign stat.div_last   = (div_cnt_reg == DIVCNT_W'(1));
    assign stat.last_ch    = (rep_ch_reg == CH_W'(NUM_CHANNELS - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take_req) begin
            req_reg   <= in_req;
            code_reg  <= in_code;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                max_reg[i] <= '0;
                min_reg[i] <= '0;
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
                ovf_reg[i] <= 1'b0;
            end
        end else if (cmd.smp_update && in_range) begin
            if (cnt_full) begin
                ovf_reg[rd_idx] <= 1'b1;
            end else begin
                if (value_reg > rd_max) begin
                    max_reg[rd_idx] <= value_reg;
                end
                if ((value_reg < rd_min) || (rd_min == '0)) begin
                    min_reg[rd_idx] <= value_reg;
                end
                sum_reg[rd_idx] <= rd_sum + SUM_W'(value_reg);
                cnt_reg[rd_idx] <= rd_cnt + COUNT_BITS'(1);
            end
        end else if (cmd.rep_load) begin
            max_reg[rd_idx] <= '0;
            min_reg[rd_idx] <= '0;
            sum_reg[rd_idx] <= '0;
            cnt_reg[rd_idx] <= '0;
            ovf_reg[rd_idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_ch_reg  <= '0;
            div_cnt_reg <= '0;
        end else begin
            if (cmd.rep_start) begin
                rep_ch_reg <= '0;
            end else if (cmd.next_ch) begin
                rep_ch_reg <= rep_ch_reg + CH_W'(1);
            end
            if (cmd.rep_load) begin
                div_cnt_reg <= DIVCNT_W'(VAL_W);
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - DIVCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rep_load) begin
            rem_reg    <= rd_sum[SUM_W-1:VAL_W];
            quo_reg    <= rd_sum[VAL_W-1:0];
            dvs_reg    <= rd_cnt;
            rmax_reg   <= rd_max;
            rmin_reg   <= rd_min;
            rempty_reg <= (rd_cnt == '0);
            rovf_reg   <= ovf_reg[rd_idx];
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_idx   <= IDX_W'(rep_ch_reg);
            out_max   <= rmax_reg;
            out_min   <= rmin_reg;
            out_mean  <= rempty_reg ? '0 : quo_reg;
            out_empty <= rempty_reg;
            out_ovf   <= rovf_reg;
            out_last  <= stat.last_ch;
        end
    end

endmodule

// ----- hdl/adc_channel_min_max_mean_stats.sv -----
// Top level of the per-channel ADC min / max / mean statistics block.
// A sample request is accepted, then one read-modify-write updates its channel entry; s_tready
//   returns high in the cycle after the update, so a new sample is taken only once the last is stored.
// A report request runs through acceptance, a decode state, then per channel one fetch, one divider
//   step per mean bit and one result load, which waits while the output register is still full.
// Reset (aresetn low, synchronous) clears every accumulator, the controller and m_tvalid.
module adc_channel_min_max_mean_stats (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [adcst_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] channel_code,
                                                       // [31:8] sample_value
    input  logic                            s_tuser,   // [0] req_type
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [adcst_pkg::M_TDATA_W-1:0] m_tdata,   // [3:0] channel_index, [27:4] max_value,
                                                       // [51:28] min_value, [75:52] mean_value,
                                                       // rest 0
    output logic [adcst_pkg::M_TUSER_W-1:0] m_tuser,   // [0] empty_flag, [1] overflow_flag
    output logic                            m_tlast    // last_flag
);
    import adcst_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic [IDX_W-1:0] out_idx;
    logic [VAL_W-1:0] out_max;
    logic [VAL_W-1:0] out_min;
    logic [VAL_W-1:0] out_mean;
    logic             out_empty;
    logic             out_ovf;

    // The controller decides what happens each cycle; it sees the datapath only through
    // the status bundle and drives it only through the command bundle.
    adcst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the accumulators for every channel, the divider and the
    // output register. The output register lets the block return to idle and take a
    // new sample while the final result of a report still waits downstream.
    adcst_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_req    (s_tuser),
        .in_code   (s_tdata[CODE_W-1:0]),
        .in_value  (s_tdata[CODE_W+VAL_W-1:CODE_W]),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_idx   (out_idx),
        .out_max   (out_max),
        .out_min   (out_min),
        .out_mean  (out_mean),
        .out_empty (out_empty),
        .out_ovf   (out_ovf),
        .out_last  (m_tlast)
    );

    // Pack the result fields, lowest field first, padded with zeros to whole bytes.
    assign m_tdata = M_TDATA_W'({out_mean, out_min, out_max, out_idx});
    assign m_tuser = {out_ovf, out_empty};

    // A result waiting downstream must never be overwritten by the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while its request was pending");

    // The block takes one request at a time: in the cycle after an acceptance it is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one was still being processed");

    // No new request is taken while the divider is working on a report.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_tready)
        else $error("request channel ready during a report");

    // A result only appears after the controller loaded one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the per-channel ADC min / max / mean statistics block.
module tb_top;
    import adcst_pkg::*;

    // The watchdog limit is ample for a correct run, even one in which every request were a
    // report under the longest idle gaps.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_GAP      = 13;
    localparam int LONG_HOLD    = 800;
    localparam int RANDOM_REQS  = 280;
    localparam int DRAIN_CYCLES = 60;
    localparam int FILL_BURST   = 12;

    localparam logic [VAL_W-1:0]      FULL_SCALE = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    // One report result, in the order in which the block emits its fields.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] max_v;
        logic [VAL_W-1:0] min_v;
        logic [VAL_W-1:0] mean_v;
        logic             empty;
        logic             ovf;
        logic             last;
    } stats_t;

    // One row of the directed table. A row with reps above one is sent back to back, and a
    // row with typed_on set replaces the prediction for channel typed.idx by typed.
    typedef struct packed {
        logic              rtype;
        logic [CODE_W-1:0] code;
        logic [VAL_W-1:0]  value;
        int                reps;
        logic              typed_on;
        stats_t            typed;
    } dir_row_t;

    // Directed requests: report straight after reset, full-scale samples, truncation of the
    // mean, a zero sample that leaves the minimum empty, codes just outside the channel range
    // and at the ends of the byte, a sum that carries into the upper bits with a truncated
    // mean, and reports that show every accumulator cleared.
    localparam dir_row_t DIR_TAB [19] = '{
        '{REQ_REPORT, 8'h00, 24'h000000, 1, 1'b1,
          '{4'd0, 24'h0, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0}},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE),      FULL_SCALE, 2, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 1),  24'd2,      1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 1),  24'd1,      1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 15), 24'd0,      1, 1'b0, '0},
        '{REQ_SAMPLE, 8'h00,                      24'h123456, 1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE - 1),  FULL_SCALE, 1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 16), FULL_SCALE, 1, 1'b0, '0},
        '{REQ_SAMPLE, 8'hFF,                      24'd1,      1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 14), 24'd1,      1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 14), 24'd0,      1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 14), 24'd5,      1, 1'b0, '0},
        '{REQ_REPORT, 8'h00, 24'h000000, 1, 1'b1,
          '{4'd1, 24'd2, 24'd1, 24'd1, 1'b0, 1'b0, 1'b0}},
        '{REQ_REPORT, 8'hFF, FULL_SCALE, 1, 1'b1,
          '{4'd0, 24'h0, 24'h0, 24'h0, 1'b1, 1'b0, 1'b0}},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 3),  FULL_SCALE, 1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 3),  24'd0,      1, 1'b0, '0},
        '{REQ_SAMPLE, CODE_W'(CHANNEL_BASE + 3),  24'd1,      1, 1'b0, '0},
        '{REQ_REPORT, 8'h5A, 24'hA5A5A5, 1, 1'b1,
          '{4'd3, FULL_SCALE, 24'd1, 24'h555555, 1'b0, 1'b0, 1'b0}},
        '{REQ_REPORT, 8'h00, 24'h000000, 1, 1'b1,
          '{4'd15, 24'h0, 24'h0, 24'h0, 1'b1, 1'b0, 1'b1}}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // Predictor state: a private copy of the per-channel accumulators.
    bit [VAL_W-1:0]      run_max [NUM_CHANNELS];
    bit [VAL_W-1:0]      run_min [NUM_CHANNELS];
    bit [SUM_W-1:0]      run_sum [NUM_CHANNELS];
    bit [COUNT_BITS-1:0] run_cnt [NUM_CHANNELS];
    bit                  run_ovf [NUM_CHANNELS];

    stats_t pending_stats [$];
    int     mismatch_cnt = 0;
    int     cycle_cnt = 0;
    int     tx_quiet = 0;
    int     rx_quiet = 0;
    bit     hold_ask = 1'b0;
    bit     hold_done = 1'b0;

    adc_channel_min_max_mean_stats dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Idle cycles before the next request on either side. Now and then a side enters a quiet
    // stretch of back-to-back requests so that both dense and sparse traffic are seen.
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // A sample updates its channel unless the code falls outside the channel range. Once the
    // count is full the sample is thrown away and only the overflow mark is set. A stored
    // minimum of zero means no minimum yet, so any sample replaces it.
    function automatic void accumulate_sample(logic [CODE_W-1:0] code, logic [VAL_W-1:0] value);
        int ch;
        ch = int'(code) - CHANNEL_BASE;
        if (ch < 0 || ch >= NUM_CHANNELS)
            return;
        if (run_cnt[ch] == COUNT_FULL) begin
            run_ovf[ch] = 1'b1;
            return;
        end
        if (value > run_max[ch])
            run_max[ch] = value;
        if (value < run_min[ch] || run_min[ch] == '0)
            run_min[ch] = value;
        run_sum[ch] += SUM_W'(value);
        run_cnt[ch] += COUNT_BITS'(1);
    endfunction

    // A report yields one result per channel in channel order, then clears everything.
    function automatic void report_stats();
        stats_t s;
        for (int n = 0; n < NUM_CHANNELS; n++) begin
            s.idx    = IDX_W'(n);
            s.max_v  = run_max[n];
            s.min_v  = run_min[n];
            s.empty  = (run_cnt[n] == '0);
            s.mean_v = s.empty ? '0 : VAL_W'(run_sum[n] / run_cnt[n]);
            s.ovf    = run_ovf[n];
            s.last   = (n == NUM_CHANNELS - 1);
            pending_stats.push_back(s);
            run_max[n] = '0;
            run_min[n] = '0;
            run_sum[n] = '0;
            run_cnt[n] = '0;
            run_ovf[n] = 1'b0;
        end
    endfunction

    // Offers one request from a falling edge and returns at the falling edge after it has been
    // taken. The valid stays high on return so that a back-to-back request follows without a
    // bubble; a gap lowers it first.
    task automatic send_req(input logic rtype, input logic [CODE_W-1:0] code,
                            input logic [VAL_W-1:0] value, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rtype;
        s_tdata  <= {value, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (rtype == REQ_REPORT)
            report_stats();
        else
            accumulate_sample(code, value);
        @(negedge aclk);
    endtask

    task automatic field_cmp(input string name, input logic [IDX_W-1:0] ch,
                             input logic [VAL_W-1:0] want, input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: channel %0d %s expected %h, got %h", $time, ch, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Result checker: every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        stats_t got;
        stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[IDX_W-1:0],
                    m_tdata[IDX_W +: VAL_W],
                    m_tdata[IDX_W + VAL_W +: VAL_W],
                    m_tdata[IDX_W + 2 * VAL_W +: VAL_W],
                    m_tuser[0], m_tuser[1], m_tlast};
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                mismatch_cnt++;
            end else begin
                want = pending_stats.pop_front();
                field_cmp("channel_index", want.idx, VAL_W'(want.idx), VAL_W'(got.idx));
                field_cmp("max_value", want.idx, want.max_v, got.max_v);
                field_cmp("min_value", want.idx, want.min_v, got.min_v);
                field_cmp("mean_value", want.idx, want.mean_v, got.mean_v);
                field_cmp("empty_flag", want.idx, VAL_W'(want.empty), VAL_W'(got.empty));
                field_cmp("overflow_flag", want.idx, VAL_W'(want.ovf), VAL_W'(got.ovf));
                field_cmp("last_flag", want.idx, VAL_W'(want.last), VAL_W'(got.last));
            end
        end
    end

    // Result sink: one ready per result, preceded by a random number of idle cycles. When the
    // request source asks for it, a single long hold-off is added so that the block backs up
    // and stops accepting requests.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = draw_gap(rx_quiet);
            if (hold_ask && !hold_done) begin
                gap += LONG_HOLD;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Request source: reset, the directed table, then random traffic.
    initial begin : request_source
        int               pick;
        int               counted;
        logic             rtype;
        logic [CODE_W-1:0] code;
        logic [VAL_W-1:0] value;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = REQ_SAMPLE;
        s_tdata  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < $size(DIR_TAB); r++) begin
            for (int k = 0; k < DIR_TAB[r].reps; k++)
                send_req(DIR_TAB[r].rtype, DIR_TAB[r].code, DIR_TAB[r].value,
                         (DIR_TAB[r].reps > 1) ? 0 : draw_gap(tx_quiet));
            // The typed expectation replaces the prediction for its channel; the results of
            // this report cannot have been taken yet, so they are still the last entries.
            if (DIR_TAB[r].typed_on)
                pending_stats[pending_stats.size() - NUM_CHANNELS + DIR_TAB[r].typed.idx]
                    = DIR_TAB[r].typed;
        end

        // Random traffic: mostly samples on valid channels with a bias towards zero, full
        // scale and small values, some reports, and a share of codes outside the range.
        // Every request sent counts towards the total.
        counted = 0;
        while (counted < RANDOM_REQS) begin
            if (counted == RANDOM_REQS / 3 && !hold_ask) begin
                // Long hold-off on the result side while a report and a run of samples are
                // offered back to back, so the input stalls behind the full output.
                hold_ask = 1'b1;
                send_req(REQ_REPORT, CODE_W'($urandom), VAL_W'($urandom), 0);
                for (int k = 0; k < FILL_BURST; k++)
                    send_req(REQ_SAMPLE,
                             CODE_W'(CHANNEL_BASE + $urandom_range(0, NUM_CHANNELS - 1)),
                             VAL_W'($urandom), 0);
                counted += FILL_BURST + 1;
            end
            if (counted == 2 * RANDOM_REQS / 3) begin
                // Pause until every outstanding result has been taken.
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (pending_stats.size() != 0);
            end

            pick  = $urandom_range(0, 99);
            rtype = (pick < 7) ? REQ_REPORT : REQ_SAMPLE;
            code  = CODE_W'($urandom);
            value = VAL_W'($urandom);
            if (pick >= 7 && pick < 15) begin
                if ($urandom_range(0, 1) == 0)
                    code = CODE_W'($urandom_range(0, CHANNEL_BASE - 1));
                else
                    code = CODE_W'($urandom_range(CHANNEL_BASE + NUM_CHANNELS, 255));
            end else if (pick >= 15) begin
                code = CODE_W'(CHANNEL_BASE + $urandom_range(0, NUM_CHANNELS - 1));
                case ($urandom_range(0, 7))
                    0: begin
                        value = '0;
                    end
                    1: begin
                        value = FULL_SCALE;
                    end
                    2: begin
                        value = VAL_W'($urandom_range(0, 15));
                    end
                    default: begin
                    end
                endcase
            end
            send_req(rtype, code, value, draw_gap(tx_quiet));
            counted++;
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_stats.size() != 0);
        // Allow any stray result to surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
